/* rtl/oaht_pkg.sv */
`default_nettype none

package oaht_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 128;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned TRIES_W = 8;
  localparam int unsigned SLOT_W  = 7;

  // commands
  localparam logic [2:0] CMD_INSERT     = 3'd0;
  localparam logic [2:0] CMD_SEARCH     = 3'd1;
  localparam logic [2:0] CMD_DELETE     = 3'd2;
  localparam logic [2:0] CMD_SET_PRICE  = 3'd3;
  localparam logic [2:0] CMD_CHANGE_KEY = 3'd4;

  // result status
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // slot state
  localparam logic [1:0] SS_NEVER = 2'd0;
  localparam logic [1:0] SS_OCC   = 2'd1;
  localparam logic [1:0] SS_TOMB  = 2'd2;

  // probe modes; the unused code probes linearly
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_EXP    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MINIT,
    S_MUL,
    S_ADDR,
    S_CHECK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [TRIES_W-1:0] tries;
    logic [1:0]         state;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [PRICE_W-1:0] price;
    logic [TRIES_W-1:0] tries;
  } res_t;

  // controls of the modular add unit: double a, add carry
  typedef struct packed {
    logic dbl;
    logic cin;
  } modu_ctl_t;

endpackage

`default_nettype wire

/* rtl/oaht_modu.sv */
`default_nettype none

// Modular adder: r = ((dbl ? 2a : a) + b + cin) mod TABLE_SIZE, for a, b below TABLE_SIZE.
module oaht_modu import oaht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic [$clog2(TABLE_SIZE)-1:0] a_i,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] b_i,
  input  wire modu_ctl_t                     ctl_i,
  output logic      [$clog2(TABLE_SIZE)-1:0] r_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [AW+1:0] SIZE_W = (AW+2)'(TABLE_SIZE);

  logic [AW+1:0] a_ext;
  logic [AW+1:0] sum;
  logic [AW+1:0] red1;
  logic [AW+1:0] red2;

  always_comb begin
    a_ext = ctl_i.dbl ? {1'b0, a_i, 1'b0} : {2'b00, a_i};
    // sum stays below three times the size: two subtracts suffice
    sum   = a_ext + {2'b00, b_i} + {{(AW+1){1'b0}}, ctl_i.cin};
    red1  = (sum >= SIZE_W) ? sum - SIZE_W : sum;
    red2  = (red1 >= SIZE_W) ? red1 - SIZE_W : red1;
    r_o   = red2[AW-1:0];
  end

endmodule

`default_nettype wire

/* rtl/oaht_store.sv */
`default_nettype none

module oaht_store import oaht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] waddr_i,
  input  wire entry_t                        wdata_i,
  input  wire logic [$clog2(TABLE_SIZE)-1:0] raddr_i,
  output entry_t                             rdata_o
);

  entry_t mem [TABLE_SIZE];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/oaht_ctrl.sv */
`default_nettype none

module oaht_ctrl import oaht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    mode_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    cmd_i,
  input  wire logic [KEY_W-1:0]              key_i,
  input  wire logic [PRICE_W-1:0]            price_i,
  input  wire logic [KEY_W-1:0]              new_key_i,
  output logic                               res_valid_o,
  input  wire logic                          res_take_i,
  output res_t                               res_o,
  output logic                               mem_we_o,
  output logic      [$clog2(TABLE_SIZE)-1:0] mem_waddr_o,
  output entry_t                             mem_wdata_o,
  output logic      [$clog2(TABLE_SIZE)-1:0] mem_raddr_o,
  input  wire entry_t                        mem_rdata_i
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned IW = $clog2(TABLE_SIZE + 1);
  localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam logic [5:0]    HASH_CNT = 6'(KEY_W - 1);
  localparam logic [5:0]    MUL_CNT  = 6'(AW - 1);
  localparam logic [AW-1:0] PW_INIT  = AW'(2 % TABLE_SIZE);
  localparam logic [AW-1:0] PW_ONE   = AW'(1);
  localparam logic [AW-1:0] LAST_ROW = AW'(TABLE_SIZE - 1);
  localparam logic [IW-1:0] I_LAST   = IW'(TABLE_SIZE);
  localparam logic [IW-1:0] I_WRAP   = IW'(TABLE_SIZE - 1);

  state_e state_q, state_d;

  logic [2:0]         cmd_q, cmd_d;
  logic [KEY_W-1:0]   wkey_q, wkey_d;
  logic [KEY_W-1:0]   nkey_q, nkey_d;
  logic [PRICE_W-1:0] wprice_q, wprice_d;
  logic               ins_q, ins_d;
  logic [AW-1:0]      h_q, h_d;
  logic [KEY_W-1:0]   sh_q, sh_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [IW-1:0]      i_q, i_d;
  logic [AW-1:0]      sq_q, sq_d;
  logic [AW-1:0]      pw_q, pw_d;
  logic [AW-1:0]      m_q, m_d;
  logic [AW-1:0]      mr_q, mr_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      clr_q, clr_d;
  res_t               res_q, res_d;

  logic [AW-1:0]  u_a;
  logic [AW-1:0]  u_b;
  modu_ctl_t      u_ctl;
  logic [AW-1:0]  u_r;

  logic [AW-1:0]  s_val;
  logic [AW-1:0]  step;
  logic           bad_cmd;
  logic           stop;
  logic           last;
  logic           found;
  logic           rewalk;
  logic [IW+7:0]  i_wide;
  logic [7:0]     tries_sat;
  logic [AW+6:0]  slot_wide;
  logic [6:0]     slot_v;
  state_e         walk_first;

  oaht_modu #(.TABLE_SIZE(TABLE_SIZE)) u_modu (
    .a_i   (u_a),
    .b_i   (u_b),
    .ctl_i (u_ctl),
    .r_o   (u_r)
  );

  assign s_val   = AW'(i_q - IW'(1));
  assign step    = (mode_i == MODE_QUAD) ? sq_q :
                   (mode_i == MODE_EXP)  ? mr_q : s_val;
  assign bad_cmd = (key_i == '0) || (cmd_i > CMD_CHANGE_KEY) ||
                   ((cmd_i == CMD_CHANGE_KEY) && (new_key_i == '0));
  assign found   = (mem_rdata_i.key == wkey_q);
  assign stop    = ins_q ? (found || (mem_rdata_i.key == '0))
                         : (found || (mem_rdata_i.state == SS_NEVER));
  assign last    = (i_q == I_LAST);
  assign rewalk  = !ins_q && found && (cmd_q == CMD_CHANGE_KEY);
  assign i_wide    = {8'b0, i_q};
  assign tries_sat = (i_wide > (IW+8)'(255)) ? 8'hFF : i_wide[7:0];
  assign slot_wide = {7'b0, idx_q};
  assign slot_v    = slot_wide[6:0];
  assign walk_first = (mode_i == MODE_EXP) ? S_MINIT : S_ADDR;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_ROW) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = bad_cmd ? S_RESULT : S_HASH;
      end
      S_HASH: begin
        if (IS_POW2 || (cnt_q == '0)) state_d = walk_first;
      end
      S_MINIT: state_d = S_MUL;
      S_MUL: begin
        if (cnt_q == '0) state_d = S_ADDR;
      end
      S_ADDR: state_d = S_CHECK;
      S_CHECK: begin
        if (stop || last) begin
          state_d = rewalk ? S_HASH : S_RESULT;
        end else begin
          state_d = walk_first;
        end
      end
      S_RESULT: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d    = cmd_q;
    wkey_d   = wkey_q;
    nkey_d   = nkey_q;
    wprice_d = wprice_q;
    ins_d    = ins_q;
    h_d      = h_q;
    sh_d     = sh_q;
    cnt_d    = cnt_q;
    i_d      = i_q;
    sq_d     = sq_q;
    pw_d     = pw_q;
    m_d      = m_q;
    mr_d     = mr_q;
    idx_d    = idx_q;
    clr_d    = clr_q;
    res_d    = res_q;
    u_a      = '0;
    u_b      = '0;
    u_ctl    = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = '0;
    in_stall_o  = (state_q != S_IDLE);
    res_valid_o = (state_q == S_RESULT);

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          wkey_d   = key_i;
          nkey_d   = new_key_i;
          wprice_d = price_i;
          ins_d    = (cmd_i == CMD_INSERT);
          res_d    = '{status: ST_MISS, default: '0};
          // start of a walk
          i_d      = IW'(1);
          sq_d     = '0;
          pw_d     = PW_INIT;
          h_d      = '0;
          sh_d     = key_i;
          cnt_d    = HASH_CNT;
        end
      end
      S_HASH: begin
        if (IS_POW2) begin
          h_d = wkey_q[AW-1:0];
        end else begin
          // Horner step of key mod size, one key bit a cycle
          u_a       = h_q;
          u_ctl.dbl = 1'b1;
          u_ctl.cin = sh_q[KEY_W-1];
          h_d       = u_r;
          sh_d      = sh_q << 1;
          cnt_d     = cnt_q - 6'd1;
        end
      end
      S_MINIT: begin
        u_a       = pw_q;
        u_ctl.cin = 1'b1;
        m_d       = u_r;
        mr_d      = '0;
        sh_d      = KEY_W'(s_val) << (KEY_W - AW);
        cnt_d     = MUL_CNT;
      end
      S_MUL: begin
        // shift-add multiply mod size, one bit of the probe offset a cycle
        u_a       = mr_q;
        u_b       = sh_q[KEY_W-1] ? m_q : '0;
        u_ctl.dbl = 1'b1;
        mr_d      = u_r;
        sh_d      = sh_q << 1;
        cnt_d     = cnt_q - 6'd1;
      end
      S_ADDR: begin
        u_a   = h_q;
        u_b   = step;
        idx_d = u_r;
      end
      S_CHECK: begin
        if (stop || last) begin
          if (ins_q) begin
            if (found) begin
              res_d = '{status: ST_DUP, slot: slot_v, price: mem_rdata_i.price,
                        tries: mem_rdata_i.tries};
            end else if (mem_rdata_i.key != '0) begin
              res_d = '{status: ST_FULL, default: '0};
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = '{key: wkey_q, price: wprice_q, tries: tries_sat,
                              state: SS_OCC};
              res_d = '{status: ST_DONE, slot: slot_v, price: wprice_q,
                        tries: tries_sat};
            end
          end else if (!found) begin
            res_d = '{status: ST_MISS, default: '0};
          end else begin
            res_d = '{status: ST_DONE, slot: slot_v, price: mem_rdata_i.price,
                      tries: mem_rdata_i.tries};
            case (cmd_q)
              CMD_SEARCH: ;
              CMD_DELETE: begin
                mem_we_o    = 1'b1;
                mem_wdata_o = '{state: SS_TOMB, default: '0};
              end
              CMD_SET_PRICE: begin
                mem_we_o    = 1'b1;
                mem_wdata_o = mem_rdata_i;
                mem_wdata_o.price = wprice_q;
                res_d.price = wprice_q;
              end
              CMD_CHANGE_KEY: begin
                // drop the old entry, then insert the new key with the old price
                mem_we_o    = 1'b1;
                mem_wdata_o = '{state: SS_TOMB, default: '0};
                wprice_d    = mem_rdata_i.price;
                wkey_d      = nkey_q;
                ins_d       = 1'b1;
                i_d         = IW'(1);
                sq_d        = '0;
                pw_d        = PW_INIT;
                h_d         = '0;
                sh_d        = nkey_q;
                cnt_d       = HASH_CNT;
              end
              default: res_d = '{status: ST_MISS, default: '0};
            endcase
          end
        end else begin
          // advance to the next probe
          i_d = i_q + IW'(1);
          if (mode_i == MODE_QUAD) begin
            u_a       = s_val;
            u_b       = sq_q;
            u_ctl.dbl = 1'b1;
            u_ctl.cin = 1'b1;
            sq_d      = u_r;
          end else if (mode_i == MODE_EXP) begin
            u_a       = pw_q;
            u_ctl.dbl = 1'b1;
            pw_d      = (i_q == I_WRAP) ? PW_ONE : u_r;
          end
        end
      end
      S_RESULT: ;
      default: ;
    endcase
  end

  assign mem_raddr_o = u_r;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    wkey_q   <= wkey_d;
    nkey_q   <= nkey_d;
    wprice_q <= wprice_d;
    ins_q    <= ins_d;
    h_q      <= h_d;
    sh_q     <= sh_d;
    cnt_q    <= cnt_d;
    i_q      <= i_d;
    sq_q     <= sq_d;
    pw_q     <= pw_d;
    m_q      <= m_d;
    mr_q     <= mr_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

/* rtl/open_addressing_hash_table.sv */
`default_nettype none

// Key/price table with open addressing and tombstone deletion.
// Input channel: in_valid_i/in_stall_o carry one command word (cmd, key, price,
// new_key). Output channel: out_valid_o/out_stall_i carry one result word
// (status, slot, price_out, tries) for every command. A word moves on a clock
// edge with valid high and stall low.
// probe_mode is written through cfg_we_i/cfg_data_i; the user must write it
// only while the table is idle, as the block itself does not enforce this.
// One command at a time: a probe passes an address and a check state in linear
// and quadratic mode, with an init and a multiply state before them in
// exponential mode, all through one shared modular adder and the table memory
// with one read and one write port. Hashing is a bit select of the key for a
// power-of-two size and a bitwise Horner reduction otherwise. A rejected
// command skips hashing and the walk. Change key walks twice.
// The result sits in an output register, so the next command is taken while
// the receiver stalls. A second result waits in the core until that register
// frees up; the input stays stalled meanwhile.
// After reset the table is cleared one slot per cycle; in_stall_o stays high
// until the clear is done. probe_mode resets to linear.
module open_addressing_hash_table import oaht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [PRICE_W-1:0] price_i,
  input  wire logic [KEY_W-1:0]   new_key_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [PRICE_W-1:0]      price_out_o,
  output logic [TRIES_W-1:0]      tries_o
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  logic [1:0] mode_q, mode_d;
  logic       out_valid_q, out_valid_d;
  res_t       out_q, out_d;

  logic          res_valid;
  logic          res_take;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  oaht_ctrl #(.TABLE_SIZE(TABLE_SIZE)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .price_i     (price_i),
    .new_key_i   (new_key_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  oaht_store #(.TABLE_SIZE(TABLE_SIZE)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    mode_d      = cfg_we_i ? cfg_data_i : mode_q;
    out_valid_d = res_take || (out_valid_q && out_stall_i);
    out_d       = res_take ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LINEAR;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign slot_o      = out_q.slot;
  assign price_out_o = out_q.price;
  assign tries_o     = out_q.tries;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  import oaht_pkg::*;

  localparam int unsigned SLOTS     = TABLE_SIZE_DEF;
  localparam int unsigned POOL_N    = 40;
  localparam int unsigned DIR_N     = 25;
  localparam int unsigned RUN_LIMIT = 40_000_000;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] CMD_UNUSED_A = 3'd5;
  localparam logic [2:0] CMD_UNUSED_B = 3'd6;
  localparam logic [2:0] CMD_UNUSED_C = 3'd7;

  localparam res_t NO_WORD   = '0;
  localparam res_t MISS_WORD = '{ST_MISS, 7'd0, 32'd0, 8'd0};

  typedef struct packed {
    logic [2:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [KEY_W-1:0]   nkey;
    logic               typed;
    res_t               want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_i = '0;
  logic [KEY_W-1:0]   key_i = '0;
  logic [PRICE_W-1:0] price_i = '0;
  logic [KEY_W-1:0]   new_key_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [SLOT_W-1:0]  slot_o;
  logic [PRICE_W-1:0] price_out_o;
  logic [TRIES_W-1:0] tries_o;

  // shadow copy of the table and the probe mode
  logic [KEY_W-1:0]   tbl_key   [SLOTS];
  logic [PRICE_W-1:0] tbl_price [SLOTS];
  logic [TRIES_W-1:0] tbl_tries [SLOTS];
  logic [1:0]         tbl_state [SLOTS];
  logic [1:0]         mode_q = MODE_LINEAR;

  res_t               pending_results [$];
  logic [KEY_W-1:0]   key_pool [POOL_N];
  logic [KEY_W-1:0]   fill_keys [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;

  open_addressing_hash_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .price_i     (price_i),
    .new_key_i   (new_key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .price_out_o (price_out_o),
    .tries_o     (tries_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Walk the probe sequence; insert stops at a zero key, search at a never-used slot.
  function automatic void probe_walk(input logic [KEY_W-1:0] key, input bit for_insert,
                                     output int unsigned where, output int unsigned cnt);
    int unsigned h, pw, idx, i, s, stp;
    bit          hit;
    h = key % SLOTS;
    pw = 1;
    idx = h;
    i = 0;
    hit = 1'b0;
    while (!hit && i < SLOTS) begin
      i++;
      s = (i - 1) % SLOTS;
      pw = (pw * 2) % SLOTS;
      if (i % SLOTS == 0) pw = 1;
      case (mode_q)
        MODE_QUAD: stp = (s * s) % SLOTS;
        MODE_EXP:  stp = (((pw + 1) % SLOTS) * s) % SLOTS;
        default:   stp = s;
      endcase
      idx = (h + stp) % SLOTS;
      if (for_insert) hit = (tbl_key[idx] == '0) || (tbl_key[idx] == key);
      else hit = (tbl_key[idx] == key) || (tbl_state[idx] == SS_NEVER);
    end
    where = idx;
    cnt = i;
  endfunction

  function automatic logic [1:0] table_insert(input logic [KEY_W-1:0] key,
                                              input logic [PRICE_W-1:0] price,
                                              output int unsigned where);
    int unsigned idx, cnt;
    probe_walk(key, 1'b1, idx, cnt);
    where = idx;
    if (tbl_key[idx] == key) return ST_DUP;
    if (tbl_key[idx] != '0) return ST_FULL;
    tbl_key[idx] = key;
    tbl_price[idx] = price;
    tbl_tries[idx] = (cnt > 255) ? 8'd255 : TRIES_W'(cnt);
    tbl_state[idx] = SS_OCC;
    return ST_DONE;
  endfunction

  function automatic void clear_slot(input int unsigned idx);
    tbl_key[idx] = '0;
    tbl_price[idx] = '0;
    tbl_tries[idx] = '0;
    tbl_state[idx] = SS_TOMB;
  endfunction

  function automatic res_t slot_word(input logic [1:0] st, input int unsigned idx);
    res_t w;
    w = '0;
    w.status = st;
    if (st == ST_DONE || st == ST_DUP) begin
      w.slot = SLOT_W'(idx);
      w.price = tbl_price[idx];
      w.tries = tbl_tries[idx];
    end
    return w;
  endfunction

  // Apply one command to the shadow table and return the word it should produce.
  function automatic res_t table_apply(input logic [2:0] cmd, input logic [KEY_W-1:0] key,
                                       input logic [PRICE_W-1:0] price,
                                       input logic [KEY_W-1:0] nkey);
    int unsigned        idx, cnt;
    logic [1:0]         st;
    logic [PRICE_W-1:0] old_price;
    res_t               w;
    if (key == '0 || cmd > CMD_CHANGE_KEY || (cmd == CMD_CHANGE_KEY && nkey == '0))
      return MISS_WORD;
    if (cmd == CMD_INSERT) begin
      st = table_insert(key, price, idx);
      return slot_word(st, idx);
    end
    probe_walk(key, 1'b0, idx, cnt);
    if (tbl_key[idx] != key) return MISS_WORD;
    case (cmd)
      CMD_DELETE: begin
        w = slot_word(ST_DONE, idx);
        clear_slot(idx);
        return w;
      end
      CMD_SET_PRICE: begin
        tbl_price[idx] = price;
      end
      CMD_CHANGE_KEY: begin
        // old entry stays deleted even when the reinsert fails
        old_price = tbl_price[idx];
        clear_slot(idx);
        st = table_insert(nkey, old_price, idx);
        return slot_word(st, idx);
      end
      default: ;
    endcase
    return slot_word(ST_DONE, idx);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 8) return $urandom;
    return key_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key(input int unsigned low);
    return {25'($urandom_range(1, 32'h1FF_FFFF)), 7'(low)};
  endfunction

  // Offer one command word and hold it until accepted.
  task automatic send_cmd(input logic [2:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [PRICE_W-1:0] price, input logic [KEY_W-1:0] nkey,
                          input bit typed, input res_t want);
    res_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    key_i <= key;
    price_i <= price;
    new_key_i <= nkey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = table_apply(cmd, key, price, nkey);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, slot_o, price_out_o, tries_o};
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: status %0d slot %0d price %0d tries %0d",
                   got.status, got.slot, got.price, got.tries);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.price !== want.price || got.tries !== want.tries) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected status %0d slot %0d price %0d tries %0d, %s %0d %0d %0d %0d",
                     want.status, want.slot, want.price, want.tries, "got",
                     got.status, got.slot, got.price, got.tries);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t          dir_rows [DIR_N];
    logic [1:0]         phase_mode [8];
    int unsigned        r, ph, n;
    logic [2:0]         c;
    logic [KEY_W-1:0]   k, nk;
    logic [PRICE_W-1:0] p;

    dir_rows = '{
      '{CMD_SEARCH,     32'd5,          32'd0,          32'd0,   1'b1, MISS_WORD},
      '{CMD_INSERT,     32'd5,          32'd0,          32'd0,   1'b1,
        '{ST_DONE, 7'd5, 32'd0, 8'd1}},
      '{CMD_INSERT,     32'd5,          32'hFFFF_FFFF,  32'd0,   1'b1,
        '{ST_DUP, 7'd5, 32'd0, 8'd1}},
      '{CMD_INSERT,     32'd133,        32'hFFFF_FFFF,  32'd0,   1'b1,
        '{ST_DONE, 7'd6, 32'hFFFF_FFFF, 8'd2}},
      '{CMD_INSERT,     32'hFFFF_FFFF,  32'h1234_5678,  32'd0,   1'b1,
        '{ST_DONE, 7'd127, 32'h1234_5678, 8'd1}},
      '{CMD_INSERT,     32'h8000_0000,  32'd1,          32'd0,   1'b1,
        '{ST_DONE, 7'd0, 32'd1, 8'd1}},
      '{CMD_SEARCH,     32'd133,        32'd0,          32'd0,   1'b0, NO_WORD},
      '{CMD_SET_PRICE,  32'd5,          32'd77,         32'd0,   1'b0, NO_WORD},
      '{CMD_DELETE,     32'd5,          32'd0,          32'd0,   1'b0, NO_WORD},
      // search runs past the tombstone
      '{CMD_SEARCH,     32'd133,        32'd0,          32'd0,   1'b0, NO_WORD},
      '{CMD_INSERT,     32'd261,        32'd9,          32'd0,   1'b0, NO_WORD},
      '{CMD_INSERT,     32'd133,        32'd0,          32'd0,   1'b0, NO_WORD},
      '{CMD_DELETE,     32'd261,        32'd0,          32'd0,   1'b0, NO_WORD},
      // insert lands on the tombstone, leaving a second copy further on
      '{CMD_INSERT,     32'd133,        32'd3,          32'd0,   1'b0, NO_WORD},
      '{CMD_CHANGE_KEY, 32'd133,        32'd0,          32'd9,   1'b0, NO_WORD},
      '{CMD_CHANGE_KEY, 32'd133,        32'd0,   32'h8000_0000,  1'b0, NO_WORD},
      '{CMD_CHANGE_KEY, 32'd9,          32'd0,          32'd0,   1'b1, MISS_WORD},
      '{CMD_INSERT,     32'd0,          32'd5,          32'd0,   1'b1, MISS_WORD},
      '{CMD_SEARCH,     32'd0,          32'd0,          32'd0,   1'b1, MISS_WORD},
      '{CMD_UNUSED_A,   32'd1,          32'd0,          32'd0,   1'b1, MISS_WORD},
      '{CMD_UNUSED_B,   32'hFFFF_FFFF,  32'd0,          32'd0,   1'b1, MISS_WORD},
      '{CMD_UNUSED_C,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, MISS_WORD},
      '{CMD_DELETE,     32'd133,        32'd0,          32'd0,   1'b1, MISS_WORD},
      '{CMD_SET_PRICE,  32'd9,          32'hFFFF_FFFF,  32'd0,   1'b0, NO_WORD},
      '{CMD_CHANGE_KEY, 32'h8000_0000,  32'd0,   32'h8000_0000,  1'b0, NO_WORD}
    };
    phase_mode = '{MODE_LINEAR, MODE_QUAD, MODE_EXP, MODE_UNUSED,
                   MODE_QUAD, MODE_EXP, MODE_LINEAR, MODE_UNUSED};

    foreach (tbl_key[i]) begin
      tbl_key[i] = '0;
      tbl_price[i] = '0;
      tbl_tries[i] = '0;
      tbl_state[i] = SS_NEVER;
    end
    // keys crowd the low hash values so that chains form
    foreach (key_pool[i]) begin
      key_pool[i] = {25'($urandom), 7'($urandom_range(0, 47))};
      if (key_pool[i] == '0) key_pool[i] = 32'h100;
    end
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'd1;
    key_pool[2] = 32'h8000_0000;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // wait out the clearing pass
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    set_mode(MODE_LINEAR);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].price, dir_rows[i].nkey,
               dir_rows[i].typed, dir_rows[i].want);

    for (ph = 0; ph < 8; ph++) begin
      set_mode(phase_mode[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      for (n = 0; n < 185; n++) begin
        if (ph == 0 && n == 40) hold_req <= 1'b1;
        if (ph == 2 && n == 90) drain();
        r = $urandom_range(0, 99);
        if (r < 35) c = CMD_INSERT;
        else if (r < 55) c = CMD_SEARCH;
        else if (r < 70) c = CMD_DELETE;
        else if (r < 82) c = CMD_SET_PRICE;
        else if (r < 96) c = CMD_CHANGE_KEY;
        else c = 3'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C));
        k = pick_key();
        nk = pick_key();
        r = $urandom_range(0, 19);
        p = (r == 0) ? '0 : (r == 1) ? '1 : PRICE_W'($urandom);
        send_cmd(c, k, p, nk, 1'b0, NO_WORD);
      end
    end

    // fill every slot, then overflow
    set_mode(MODE_LINEAR);
    send_idle_pct = 0;
    stall_pct = 0;
    for (n = 0; n < SLOTS + 8; n++) begin
      k = fresh_key(n % SLOTS);
      fill_keys.push_back(k);
      send_cmd(CMD_INSERT, k, PRICE_W'($urandom), '0, 1'b0, NO_WORD);
    end

    for (ph = 0; ph < 2; ph++) begin
      set_mode((ph == 0) ? MODE_QUAD : MODE_EXP);
      send_idle_pct = 32;
      stall_pct = 32;
      for (n = 0; n < 30; n++) begin
        k = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
        nk = fresh_key($urandom_range(0, SLOTS - 1));
        case ($urandom_range(0, 5))
          0: c = CMD_SEARCH;
          1: begin c = CMD_SEARCH; k = nk; end
          2: c = CMD_CHANGE_KEY;
          3: begin c = CMD_INSERT; k = nk; end
          4: c = CMD_SET_PRICE;
          default: c = CMD_DELETE;
        endcase
        send_cmd(c, k, PRICE_W'($urandom), nk, 1'b0, NO_WORD);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
